/* rtl/core/rmc_pkg.sv */
// ----------------------------------------------------------------------------
// rmc_pkg: shared types and constants of the rotation matrix composer
// Number formats, operation codes, CORDIC arctangent table, sequencer states.
// ----------------------------------------------------------------------------
package rmc_pkg;

   localparam int FRAC_BITS    = 30;
   localparam int ANGLE_WIDTH  = 16;
   localparam int CORDIC_STEPS = 30;
   localparam int ELEM_W       = 32;
   localparam int ACC_W        = 36;  // CORDIC x/y and step matrix entries
   localparam int ZW           = 33;  // CORDIC residual angle
   localparam int SUM_W        = 70;  // four 32x32 products plus headroom
   localparam int TRIG_SH      = 30 - FRAC_BITS;  // CORDIC Q30 to element format

   localparam logic signed [ACC_W-1:0] CORDIC_GAIN = 36'sd652032874;
   localparam logic signed [ACC_W-1:0] ONE_VAL     = ACC_W'(64'sd1 <<< FRAC_BITS);

   typedef enum logic [2:0] {
      OP_ROT_X  = 3'd0,
      OP_ROT_Y  = 3'd1,
      OP_ROT_Z  = 3'd2,
      OP_ROT_XY = 3'd3,
      OP_IDENT  = 3'd4
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_COR1,     // CORDIC for first angle
      ST_COR2,     // CORDIC for second angle (op 3)
      ST_STEP,     // compose Rx*Ry into step matrix
      ST_MUL,      // step * M, read-modify-write
      ST_IDENT,    // write identity
      ST_EMIT      // stream 16 words out
   } state_type;

   typedef struct packed {
      logic       start;
      logic       run;     // advance one micro-rotation
      logic [4:0] step;
   } cor_ctl_type;

   function automatic logic [ZW-1:0] atan_lut(input logic [4:0] i);
      logic [31:0] v;
      case (i)
         5'd0:  v = 32'h20000000; 5'd1:  v = 32'h12E4051E; 5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4; 5'd4:  v = 32'h028B0D43; 5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E; 5'd7:  v = 32'h00517C55; 5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2F; 5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3; 5'd14: v = 32'h0000A2FA;
         5'd15: v = 32'h0000517D; 5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A30; 5'd19: v = 32'h00000518; 5'd20: v = 32'h0000028C;
         5'd21: v = 32'h00000146; 5'd22: v = 32'h000000A3; 5'd23: v = 32'h00000051;
         5'd24: v = 32'h00000029; 5'd25: v = 32'h00000014; 5'd26: v = 32'h0000000A;
         5'd27: v = 32'h00000005; 5'd28: v = 32'h00000003; 5'd29: v = 32'h00000001;
         default: v = 32'h0;
      endcase
      return {1'b0, v};
   endfunction

   // round half up from Q30 and clamp to +-1.0
   function automatic logic signed [ACC_W-1:0] trig_fix(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W:0] half, r;
      half = ((ACC_W+1)'(64'sd1) <<< TRIG_SH) >>> 1;
      r = ((ACC_W+1)'(v) + half) >>> TRIG_SH;
      if (r > (ACC_W+1)'(ONE_VAL))  r = (ACC_W+1)'(ONE_VAL);
      if (r < -(ACC_W+1)'(ONE_VAL)) r = -(ACC_W+1)'(ONE_VAL);
      return r[ACC_W-1:0];
   endfunction

endpackage

/* rtl/core/rmc_cordic.sv */
// ----------------------------------------------------------------------------
// rmc_cordic: iterative CORDIC sine/cosine
// One micro-rotation per cycle while ctl.run is high, 30 steps, quadrant fold and rounding at end.
// ----------------------------------------------------------------------------
module rmc_cordic (
   input  logic                                  clock,
   input  logic                                  reset,
   input  rmc_pkg::cor_ctl_type                  ctl,
   input  logic [rmc_pkg::ANGLE_WIDTH-1:0]       angle,
   output logic signed [rmc_pkg::ACC_W-1:0]      sin_val,
   output logic signed [rmc_pkg::ACC_W-1:0]      cos_val
);
   logic signed [rmc_pkg::ACC_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [rmc_pkg::ZW-1:0]    z_ff, z_in;
   logic [1:0]                       quad_ff, quad_in;
   logic [31:0]                      a32;
   logic signed [rmc_pkg::ACC_W-1:0] dx, dy, c, s;

   assign a32 = {angle, {(32 - rmc_pkg::ANGLE_WIDTH){1'b0}}};

   // x/y/z hold their values while not running, so results stay put
   always_comb begin
      dx = y_ff >>> ctl.step;
      dy = x_ff >>> ctl.step;
      x_in = x_ff; y_in = y_ff; z_in = z_ff; quad_in = quad_ff;
      if (ctl.start) begin
         x_in = rmc_pkg::CORDIC_GAIN;
         y_in = '0;
         z_in = {3'b000, a32[29:0]};
         quad_in = a32[31:30];
      end else if (ctl.run && !z_ff[rmc_pkg::ZW-1]) begin
         x_in = x_ff - dx; y_in = y_ff + dy;
         z_in = z_ff - rmc_pkg::atan_lut(ctl.step);
      end else if (ctl.run) begin
         x_in = x_ff + dx; y_in = y_ff - dy;
         z_in = z_ff + rmc_pkg::atan_lut(ctl.step);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quad_ff <= '0;
      end else begin
         quad_ff <= quad_in;
      end
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in;
   end

   always_comb begin
      case (quad_ff)
         2'd0:    begin c = x_ff;  s = y_ff;  end
         2'd1:    begin c = -y_ff; s = x_ff;  end
         2'd2:    begin c = -x_ff; s = -y_ff; end
         default: begin c = y_ff;  s = -x_ff; end
      endcase
      sin_val = rmc_pkg::trig_fix(s);
      cos_val = rmc_pkg::trig_fix(c);
   end
endmodule

/* rtl/core/rmc_mac.sv */
// ----------------------------------------------------------------------------
// rmc_mac: shared multiply-accumulate with round and saturate
// One 32x32 product per cycle while en is high, into a wide accumulator.
// ----------------------------------------------------------------------------
module rmc_mac (
   input  logic                                clock,
   input  logic                                clear,
   input  logic                                en,
   input  logic signed [rmc_pkg::ELEM_W-1:0]   a,
   input  logic signed [rmc_pkg::ELEM_W-1:0]   b,
   output logic signed [rmc_pkg::ELEM_W-1:0]   result
);
   logic signed [rmc_pkg::SUM_W-1:0] acc_ff, acc_in, rnd;
   logic signed [2*rmc_pkg::ELEM_W-1:0] prod;

   assign prod = a * b;

   always_comb begin
      acc_in = acc_ff;
      if (clear)   acc_in = '0;
      else if (en) acc_in = acc_ff + rmc_pkg::SUM_W'(prod);
      rnd = (acc_ff + rmc_pkg::SUM_W'(64'sd1 <<< (rmc_pkg::FRAC_BITS - 1)))
            >>> rmc_pkg::FRAC_BITS;
      if (rnd > rmc_pkg::SUM_W'(64'sd2147483647))       result = 32'h7FFFFFFF;
      else if (rnd < -rmc_pkg::SUM_W'(64'sd2147483648)) result = 32'h80000000;
      else                                               result = rnd[31:0];
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end
endmodule

/* rtl/core/rotation_matrix_composer_top.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_composer_top: accumulated 4x4 rotation matrix
// One command at a time: req_tready is high only in idle, so a new command is
// taken only after all 16 words of the last one have left. All matrix
// products go through the single shared MAC.
// Reset: synchronous; an identity sweep of the matrix memory
// follows, with req_tready low.
// ----------------------------------------------------------------------------
module rotation_matrix_composer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [2:0] operation, [18:3] angle_first,
                                    // [34:19] angle_second, [39:35] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] element, [35:32] element_index,
                                    // [39:36] zero
   output logic        rsp_tlast
);
   rmc_pkg::state_type state_ff, state_in;
   logic [2:0]  op_ff;
   logic [15:0] ang1_ff, ang2_ff;
   logic [6:0]  cnt_ff, cnt_in;      // sequencer step
   logic        init_ff;             // identity sweep pending after reset
   logic        cor_sel_ff;

   // matrix memory (M) and step matrix registers
   logic signed [31:0] mem [16];
   logic [3:0]         mem_waddr, mem_raddr;
   logic               mem_we;
   logic signed [31:0] mem_wdata, mem_rdata_ff;
   logic signed [35:0] step_ff [16];  // column-major step matrix R
   logic signed [35:0] rx_ff [16];
   logic signed [31:0] colbuf_ff [4]; // Rx*Ry column being built
   logic signed [31:0] mcol_ff [4];   // R*M column waiting for write-back
   logic [2:0]         wb_ff;         // write-back words left
   logic [1:0]         wb_col_ff, wb_row;

   rmc_pkg::cor_ctl_type cctl;
   logic signed [35:0] sn, cs;
   logic signed [35:0] a_sel;
   logic signed [31:0] mac_a, mac_b;
   logic        mac_clr, mac_en;
   logic signed [31:0] mac_res;

   // output path
   logic               emit_rd;       // EMIT is reading the memory
   logic [3:0]         rd_idx_ff;
   logic               rd_pend_ff;    // read data ready for the output register
   logic               ov_ff;
   logic [3:0]         oidx_ff;
   logic signed [31:0] oel_ff;

   // MAC schedule inside an element: ph 0 clears and issues the read of j=0,
   // ph 1..4 accumulate j=0..3, ph 5 has the rounded result. el = col*4+row.
   logic [3:0] el;
   logic [2:0] ph;
   logic [1:0] jd;    // j whose read data is present (read issued in the previous cycle)

   // rotation matrix entry i (column-major) for an operation code;
   // X rotation for op 3 and any other code
   function automatic logic signed [35:0] rot_elem(input logic [2:0] op,
                                                  input logic [3:0] i,
                                                  input logic signed [35:0] s,
                                                  input logic signed [35:0] c);
      logic signed [35:0] v;
      v = (i[1:0] == i[3:2]) ? rmc_pkg::ONE_VAL : '0;
      case (op)
         rmc_pkg::OP_ROT_Y: begin
            case (i)
               4'd0, 4'd10: v = c;
               4'd8:        v = s;
               4'd2:        v = -s;
               default: ;
            endcase
         end
         rmc_pkg::OP_ROT_Z: begin
            case (i)
               4'd0, 4'd5: v = c;
               4'd4:       v = -s;
               4'd1:       v = s;
               default: ;
            endcase
         end
         default: begin
            case (i)
               4'd5, 4'd10: v = c;
               4'd9:        v = -s;
               4'd6:        v = s;
               default: ;
            endcase
         end
      endcase
      return v;
   endfunction

   rmc_cordic u_cordic (
      .clock(clock), .reset(reset), .ctl(cctl),
      .angle(cor_sel_ff ? ang2_ff : ang1_ff), .sin_val(sn), .cos_val(cs)
   );

   rmc_mac u_mac (
      .clock(clock), .clear(mac_clr), .en(mac_en),
      .a(mac_a), .b(mac_b), .result(mac_res)
   );

   assign el = cnt_ff[6:3];
   assign ph = cnt_ff[2:0];
   assign jd = 2'(ph - 3'd1);

   // STEP rewrites step_ff column by column, so Rx comes from its copy
   assign a_sel = (state_ff == rmc_pkg::ST_STEP) ? rx_ff[{jd, el[1:0]}]
                                                 : step_ff[{jd, el[1:0]}];

   // R entries stay within +-1.0, so 32 bits carry them
   always_comb begin
      mac_clr = (ph == 3'd0);
      mac_en  = (ph >= 3'd1) && (ph <= 3'd4);
      mac_a   = 32'(a_sel);
      if (state_ff == rmc_pkg::ST_STEP)
         mac_b = 32'(rot_elem(rmc_pkg::OP_ROT_Y, {el[3:2], jd}, sn, cs));
      else
         mac_b = mem_rdata_ff;
   end

   // CORDIC run: cnt 0 loads, 1..30 rotate, 31 results settled
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cctl.start = 1'b0;
      cctl.run   = 1'b0;
      cctl.step  = cnt_ff[4:0];
      case (state_ff)
         rmc_pkg::ST_IDLE: begin
            cnt_in = '0;
            if (init_ff) state_in = rmc_pkg::ST_IDENT;
            else if (req_tvalid) begin
               case (req_tdata[2:0])
                  rmc_pkg::OP_ROT_X, rmc_pkg::OP_ROT_Y, rmc_pkg::OP_ROT_Z,
                  rmc_pkg::OP_ROT_XY: state_in = rmc_pkg::ST_COR1;
                  rmc_pkg::OP_IDENT:  state_in = rmc_pkg::ST_IDENT;
                  default:            state_in = rmc_pkg::ST_EMIT;
               endcase
            end
         end
         rmc_pkg::ST_COR1, rmc_pkg::ST_COR2: begin
            cctl.start = (cnt_ff == 7'd0);
            cctl.run   = (cnt_ff != 7'd0) && (cnt_ff <= 7'd30);
            cctl.step  = 5'(cnt_ff - 7'd1);
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd31) begin
               cnt_in = '0;
               if (state_ff == rmc_pkg::ST_COR1 && op_ff == rmc_pkg::OP_ROT_XY)
                  state_in = rmc_pkg::ST_COR2;
               else if (state_ff == rmc_pkg::ST_COR2) state_in = rmc_pkg::ST_STEP;
               else state_in = rmc_pkg::ST_MUL;
            end
         end
         rmc_pkg::ST_STEP, rmc_pkg::ST_MUL: begin
            cnt_in = (ph == 3'd5) ? {el + 4'd1, 3'd0} : cnt_ff + 7'd1;
            if (ph == 3'd5 && el == 4'd15) begin
               cnt_in = '0;
               state_in = (state_ff == rmc_pkg::ST_STEP) ? rmc_pkg::ST_MUL
                                                         : rmc_pkg::ST_EMIT;
            end
         end
         rmc_pkg::ST_IDENT: begin
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd15) begin
               cnt_in = '0;
               state_in = init_ff ? rmc_pkg::ST_IDLE : rmc_pkg::ST_EMIT;
            end
         end
         rmc_pkg::ST_EMIT: begin
            if (rsp_tvalid && rsp_tready) begin
               cnt_in = cnt_ff + 7'd1;
               if (cnt_ff[3:0] == 4'd15) begin
                  cnt_in = '0;
                  state_in = rmc_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = rmc_pkg::ST_IDLE;
      endcase
   end

   // memory control: identity sweep or column write-back; one read port
   always_comb begin
      req_tready = (state_ff == rmc_pkg::ST_IDLE) && !init_ff;
      wb_row    = wb_ff[1:0];
      mem_we    = 1'b0;
      mem_waddr = {wb_col_ff, wb_row};
      mem_wdata = mcol_ff[wb_row];
      mem_raddr = {el[3:2], ph[1:0]};
      emit_rd   = 1'b0;
      if (state_ff == rmc_pkg::ST_IDENT) begin
         mem_waddr = cnt_ff[3:0];
         mem_wdata = (cnt_ff[1:0] == cnt_ff[3:2]) ? 32'(rmc_pkg::ONE_VAL) : '0;
         mem_we = 1'b1;
      end else if (wb_ff != 3'd0) begin
         mem_we = 1'b1;
      end
      if (state_ff == rmc_pkg::ST_EMIT) begin
         mem_raddr = cnt_ff[3:0];
         emit_rd = 1'b1;
      end
   end

   // New column c of M depends only on old column c, but rows of column c
   // still read it, so a finished column is staged and written back after.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= rmc_pkg::ST_IDLE;
         cnt_ff     <= '0;
         init_ff    <= 1'b1;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (state_ff == rmc_pkg::ST_IDENT && cnt_ff == 7'd15) init_ff <= 1'b0;
         rd_pend_ff <= emit_rd && !(rsp_tvalid && rsp_tready) && !rd_pend_ff;
      end
      if (req_tvalid && req_tready) begin
         op_ff   <= req_tdata[2:0];
         ang1_ff <= req_tdata[18:3];
         ang2_ff <= req_tdata[34:19];
      end
      if (state_ff == rmc_pkg::ST_IDLE) cor_sel_ff <= 1'b0;
      else if (state_ff == rmc_pkg::ST_COR1 && cnt_ff == 7'd31) cor_sel_ff <= 1'b1;
      // step matrix from the settled first CORDIC run
      if (state_ff == rmc_pkg::ST_COR1 && cnt_ff == 7'd31) begin
         for (int i = 0; i < 16; i++)
            step_ff[i] <= rot_elem(op_ff, 4'(i), sn, cs);
      end else if (state_ff == rmc_pkg::ST_STEP && ph == 3'd5 && el[1:0] == 2'd3) begin
         for (int r = 0; r < 4; r++)
            step_ff[{el[3:2], 2'(r)}] <= (r == 3) ? 36'(mac_res) : 36'(colbuf_ff[r]);
      end
      if (state_ff == rmc_pkg::ST_COR2 && cnt_ff == 7'd0) rx_ff <= step_ff;
      if (state_ff == rmc_pkg::ST_STEP && ph == 3'd5) colbuf_ff[el[1:0]] <= mac_res;
   end

   // matrix memory: one write and one registered read port
   always_ff @(posedge clock) begin
      if (state_ff == rmc_pkg::ST_MUL && ph == 3'd5) mcol_ff[el[1:0]] <= mac_res;
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      mem_rdata_ff <= mem[mem_raddr];
   end

   // column write-back of R*M: four words right after each column ends
   always_ff @(posedge clock) begin
      if (reset) wb_ff <= '0;
      else if (state_ff == rmc_pkg::ST_MUL && ph == 3'd5 && el[1:0] == 2'd3) begin
         wb_ff <= 3'd4; wb_col_ff <= el[3:2];
      end else if (wb_ff != 3'd0) wb_ff <= wb_ff - 3'd1;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) ov_ff <= 1'b0;
      else if (rsp_tvalid && rsp_tready) ov_ff <= 1'b0;
      else if (rd_pend_ff) ov_ff <= 1'b1;
      if (rd_pend_ff && !ov_ff) begin
         oel_ff <= mem_rdata_ff; oidx_ff <= rd_idx_ff;
      end
      rd_idx_ff <= cnt_ff[3:0];
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {4'd0, oidx_ff, oel_ff};
   assign rsp_tlast  = (oidx_ff == 4'd15);
endmodule

/* bench/tb_rotation_matrix_composer_top.sv */
// ----------------------------------------------------------------------------
// tb_rotation_matrix_composer_top: self-checking bench of the matrix composer
// Streams rotation commands with random gaps, predicts the accumulated 4x4
// matrix in fixed point, and checks every emitted element, index and tlast.
// ----------------------------------------------------------------------------
module tb_rotation_matrix_composer_top;
   import rmc_pkg::*;

   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] ang1;
      logic [15:0] ang2;
   } cmd_type;

   typedef struct packed {
      logic [31:0] element;
      logic [3:0]  index;
      logic        last;
   } elem_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;

   rotation_matrix_composer_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   cmd_type     cmd_queue[$];     // commands waiting to be driven
   elem_type    elem_queue[$];    // predicted words, oldest first
   longint      view_mat[16];     // predicted accumulated matrix
   int          errors = 0;
   int          words_seen = 0;
   int          cmds_sent = 0;
   bit          stim_done = 0;
   bit          req_gaps = 1;     // random idling on input side
   bit          rsp_gaps = 1;     // random stalls on output side
   int          hold_off = 0;     // long receiver stall, counted down
   int          idle_cycles = 0;
   localparam int WATCHDOG = 5000;

   // ---------------- predictor ----------------
   function automatic longint floor_sh(longint v, int s);
      return v >>> s;             // arithmetic shift floors
   endfunction

   function automatic void ident(ref longint m[16]);
      for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? (64'sd1 <<< FRAC_BITS) : 0;
   endfunction

   // CORDIC sine/cosine of a binary angle, quadrant folded, Q-format rounded
   function automatic void trig(logic [15:0] ang, output longint sn, output longint cs);
      longint atan_k[30] = '{
         'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43,
         'h0145D7E1, 'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F,
         'h000A2F98, 'h000517CC, 'h00028BE6, 'h000145F3, 'h0000A2FA,
         'h0000517D, 'h000028BE, 'h0000145F, 'h00000A30, 'h00000518,
         'h0000028C, 'h00000146, 'h000000A3, 'h00000051, 'h00000029,
         'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001};
      logic [31:0] a32;
      longint x, y, z, dx, dy, c, s, one;
      int sh;
      a32 = {ang[ANGLE_WIDTH-1:0], {(32-ANGLE_WIDTH){1'b0}}};
      z = a32[29:0];
      x = 652032874;
      y = 0;
      for (int i = 0; i < 30; i++) begin
         dx = floor_sh(y, i);
         dy = floor_sh(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_k[i];
         end else begin
            x += dx; y -= dy; z += atan_k[i];
         end
      end
      case (a32[31:30])
         2'd0: begin c = x;  s = y;  end
         2'd1: begin c = -y; s = x;  end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
      sh = 30 - FRAC_BITS;
      if (sh > 0) begin
         c = floor_sh(c + (64'sd1 <<< (sh - 1)), sh);
         s = floor_sh(s + (64'sd1 <<< (sh - 1)), sh);
      end
      one = 64'sd1 <<< FRAC_BITS;
      if (c > one) c = one;
      if (c < -one) c = -one;
      if (s > one) s = one;
      if (s < -one) s = -one;
      sn = s;
      cs = c;
   endfunction

   // dst = a * b with round half up and 32-bit saturation
   function automatic void mat_product(longint a[16], longint b[16], ref longint dst[16]);
      longint sum, r;
      longint tmp[16];
      for (int col = 0; col < 4; col++)
         for (int row = 0; row < 4; row++) begin
            sum = 0;
            for (int j = 0; j < 4; j++) sum += a[j*4+row] * b[col*4+j];
            r = floor_sh(sum + (64'sd1 <<< (FRAC_BITS - 1)), FRAC_BITS);
            if (r > 64'sd2147483647) r = 64'sd2147483647;
            if (r < -64'sd2147483648) r = -64'sd2147483648;
            tmp[col*4+row] = r;
         end
      dst = tmp;
   endfunction

   // axis: 0 X, 1 Y, 2 Z
   function automatic void axis_rot(int axis, logic [15:0] ang, ref longint r[16]);
      longint s, c;
      trig(ang, s, c);
      ident(r);
      case (axis)
         0: begin r[5] = c; r[9] = -s; r[6] = s; r[10] = c; end
         1: begin r[0] = c; r[8] = s; r[2] = -s; r[10] = c; end
         default: begin r[0] = c; r[4] = -s; r[1] = s; r[5] = c; end
      endcase
   endfunction

   function automatic void apply_cmd(cmd_type cmd);
      longint rot[16], rot_y[16];
      elem_type w;
      case (cmd.op)
         OP_ROT_X, OP_ROT_Y, OP_ROT_Z: begin
            axis_rot(int'(cmd.op), cmd.ang1, rot);
            mat_product(rot, view_mat, view_mat);
         end
         OP_ROT_XY: begin
            axis_rot(0, cmd.ang1, rot);
            axis_rot(1, cmd.ang2, rot_y);
            mat_product(rot, rot_y, rot);
            mat_product(rot, view_mat, view_mat);
         end
         OP_IDENT: ident(view_mat);
         default: ;               // unused codes leave the matrix alone
      endcase
      for (int k = 0; k < 16; k++) begin
         w.element = view_mat[k][31:0];
         w.index   = k[3:0];
         w.last    = (k == 15);
         elem_queue.push_back(w);
      end
   endfunction

   // ---------------- driver ----------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_cmd(cmd_queue.pop_front());
            cmds_sent++;
         end
         // offer the head word unless idling; hold a word once offered
         if (cmd_queue.size() > 0 && (!req_tvalid || req_tready || 1'b1)) begin
            if ((req_tvalid && !req_tready) ||
                !(req_gaps && $urandom_range(99) < 18)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= {5'b0, cmd_queue[0].ang2, cmd_queue[0].ang1, cmd_queue[0].op};
            end else begin
               req_tvalid <= 1'b0;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------- monitor / receiver ----------------
   always @(posedge clock) begin
      elem_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            words_seen++;
            got.element = rsp_tdata[31:0];
            got.index   = rsp_tdata[35:32];
            got.last    = rsp_tlast;
            if (elem_queue.size() == 0) begin
               $error("unexpected word: element %h index %0d", got.element, got.index);
               errors++;
            end else begin
               want = elem_queue.pop_front();
               if (got.element !== want.element) begin
                  $error("element: expected %h actual %h", want.element, got.element);
                  errors++;
               end
               if (got.index !== want.index) begin
                  $error("element_index: expected %0d actual %0d", want.index, got.index);
                  errors++;
               end
               if (got.last !== want.last) begin
                  $error("last: expected %0d actual %0d", want.last, got.last);
                  errors++;
               end
            end
         end
         if (hold_off > 0) begin
            hold_off--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !(rsp_gaps && $urandom_range(99) < 18);
         end
      end
   end

   // watchdog: cycles with no handshake on either side
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   function automatic cmd_type rand_cmd();
      cmd_type c;
      int pick;
      pick = $urandom_range(99);
      if (pick < 4) c.op = 3'($urandom_range(7, 5));      // unused codes
      else if (pick < 10) c.op = OP_IDENT;
      else c.op = 3'($urandom_range(3));
      c.ang1 = 16'($urandom);
      c.ang2 = 16'($urandom);
      // sometimes pick angles near quadrant boundaries
      if ($urandom_range(9) == 0) c.ang1 = {2'($urandom), 14'h0} + 16'($urandom_range(2)) - 16'd1;
      return c;
   endfunction

   task automatic push(logic [2:0] op, logic [15:0] a1, logic [15:0] a2);
      cmd_type c;
      c.op = op; c.ang1 = a1; c.ang2 = a2;
      cmd_queue.push_back(c);
   endtask

   task automatic drain();
      while (cmd_queue.size() > 0 || elem_queue.size() > 0) @(posedge clock);
   endtask

   initial begin
      ident(view_mat);
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: every op, angle extremes, quadrant edges, unused codes
      push(OP_IDENT,  16'h0000, 16'h0000);
      push(OP_ROT_X,  16'h0000, 16'hFFFF);
      push(OP_ROT_X,  16'h4000, 16'h0000);
      push(OP_ROT_Y,  16'h7FFF, 16'h1234);
      push(OP_ROT_Z,  16'h8000, 16'h0000);
      push(OP_ROT_Z,  16'hFFFF, 16'h0000);
      push(OP_ROT_Y,  16'hC000, 16'h0000);
      push(OP_ROT_XY, 16'h2000, 16'hE000);
      push(OP_ROT_XY, 16'h8000, 16'h7FFF);
      push(OP_ROT_XY, 16'hFFFF, 16'h8000);
      push(3'd5,      16'h5555, 16'hAAAA);
      push(3'd6,      16'hAAAA, 16'h5555);
      push(3'd7,      16'hFFFF, 16'hFFFF);
      push(OP_ROT_Z,  16'h3FFF, 16'h0000);
      push(OP_ROT_X,  16'hBFFF, 16'h0000);
      push(OP_IDENT,  16'hFFFF, 16'hFFFF);
      push(OP_ROT_Y,  16'h0001, 16'h0000);
      drain();

      // random phase with gaps on both sides
      for (int i = 0; i < 120; i++) cmd_queue.push_back(rand_cmd());
      drain();

      // no idling at all, with a long receiver stall at its start while input keeps coming
      req_gaps = 0;
      rsp_gaps = 0;
      for (int i = 0; i < 60; i++) cmd_queue.push_back(rand_cmd());
      hold_off = 600;
      drain();

      req_gaps = 1;
      rsp_gaps = 1;
      for (int i = 0; i < 70; i++) cmd_queue.push_back(rand_cmd());
      drain();
      stim_done = 1;
      repeat (250) @(posedge clock);

      $display("Covered %0d commands (all ops, unused codes, angle extremes) and %0d words,",
               cmds_sent, words_seen);
      $display("with random gaps, a gap-free stretch and a long output stall.");
      if (errors == 0 && elem_queue.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

/* sim.f */
rtl/core/rmc_pkg.sv
rtl/core/rmc_cordic.sv
rtl/core/rmc_mac.sv
rtl/core/rotation_matrix_composer_top.sv
bench/tb_rotation_matrix_composer_top.sv
